>>> design/pn_pkg.sv
// Shared types and constants of the path normalizer.
package pn_pkg;

  localparam int PATH_BYTES = 256;
  localparam int PTR_W = $clog2(PATH_BYTES);
  localparam int LEN_W = PTR_W + 1;
  localparam int SUM_W = PTR_W + 2;
  localparam logic [SUM_W-1:0] PATH_LIMIT = SUM_W'(PATH_BYTES);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  localparam logic [7:0] SLASH = 8'h2F;
  localparam logic [7:0] DOT = 8'h2E;

  typedef enum logic [1:0] {
    REQ_BASE = 2'd0,
    REQ_REL  = 2'd1,
    REQ_END  = 2'd2,
    REQ_READ = 2'd3
  } req_kind_t;

  typedef enum logic {
    RES_SUMMARY = 1'b0,
    RES_READ    = 1'b1
  } res_kind_t;

  typedef struct packed {
    req_kind_t  req_type;
    logic [7:0] path_byte;
    logic [7:0] read_index;
  } req_t;

  typedef struct packed {
    res_kind_t  result_kind;
    logic [7:0] data_byte;
    logic [7:0] path_length;
    logic       too_long;
  } rsp_t;

  // Classified item as it waits between the front and the back.
  typedef struct packed {
    req_kind_t        kind;
    logic [7:0]       path_byte;
    logic [PTR_W-1:0] index;
    logic             rd_ok;
    logic             is_slash;
  } q_item_t;

endpackage

>>> design/pn_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/pn_front.sv
// Front end: accepts request items, classifies them and queues them for the back end.
module pn_front
  import pn_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_stall,
  input  req_t    req,
  output logic    q_valid,
  output q_item_t q_item,
  input  logic    q_pop
);

  q_item_t            q_mem [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               push;
  logic               pop;
  q_item_t            new_item;

  assign req_stall = (count == QCNT_W'(QDEPTH));
  assign push = req_valid && !req_stall;
  assign q_valid = (count != '0);
  assign pop = q_pop && q_valid;
  assign q_item = q_mem[rd_ptr];

  always_comb begin
    new_item.kind = req.req_type;
    new_item.path_byte = req.path_byte;
    new_item.index = PTR_W'(req.read_index);
    new_item.rd_ok = (int'(req.read_index) < PATH_BYTES);
    new_item.is_slash = (req.path_byte == SLASH);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

>>> design/pn_back.sv
// Back end: sequencer that edits the path buffer and produces result items.
module pn_back
  import pn_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    q_valid,
  input  q_item_t q_item,
  output logic    q_pop,
  output logic    rsp_valid,
  input  logic    rsp_stall,
  output rsp_t    rsp
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_BYTE   = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_FINAL  = 5'b01000,
    ST_RDWAIT = 5'b10000
  } state_t;

  typedef enum logic [2:0] {
    PH_BASE = 3'b001,
    PH_REL  = 3'b010,
    PH_DONE = 3'b100
  } phase_t;

  state_t           state, state_next;
  phase_t           phase, phase_next;
  logic [PTR_W-1:0] used, used_next;
  logic [PTR_W-1:0] mark, mark_next;
  logic [LEN_W-1:0] len, len_next;
  logic             dots, dots_next;
  logic             ovf, ovf_next;
  logic [PTR_W-1:0] trim, trim_next;
  logic [PTR_W-1:0] scan, scan_next;
  logic [7:0]       cur_byte, cur_byte_next;
  logic             cur_end, cur_end_next;
  logic             rd_ok, rd_ok_next;
  logic             rsp_valid_next;
  rsp_t             rsp_next;

  logic             ram_we;
  logic [PTR_W-1:0] ram_waddr;
  logic [7:0]       ram_wdata;
  logic             ram_re;
  logic [PTR_W-1:0] ram_raddr;
  logic [7:0]       ram_rdata;

  // Values after an implicit new request and after the switch to relative bytes.
  logic             fresh;
  logic             in_base;
  logic             absolute;
  logic [PTR_W-1:0] e_used;
  logic             e_ovf;
  logic [PTR_W-1:0] e_trim;
  logic [PTR_W-1:0] b_used;
  logic             b_ovf;
  logic [LEN_W-1:0] b_len;
  logic             b_dots;
  logic             fin_none;
  logic             fin_up;
  logic [SUM_W-1:0] comp_end;
  logic [SUM_W-1:0] byte_pos;
  logic [LEN_W-1:0] len_inc;
  logic [SUM_W-1:0] grown_end;
  logic             out_free;

  pn_ram #(
    .WIDTH(8),
    .DEPTH(PATH_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign out_free = !rsp_valid || !rsp_stall;

  always_comb begin
    fresh = (phase == PH_DONE) && (q_item.kind != REQ_READ);
    e_used = fresh ? '0 : used;
    e_ovf = fresh ? 1'b0 : ovf;
    e_trim = fresh ? '0 : trim;
    in_base = fresh || (phase == PH_BASE);
    absolute = in_base && (q_item.kind == REQ_REL) && q_item.is_slash;
    b_ovf = absolute ? 1'b0 : e_ovf;
    if (absolute) begin
      b_used = '0;
    end else if (in_base && !e_ovf) begin
      b_used = e_trim;
    end else begin
      b_used = e_used;
    end
    b_len = (in_base || fresh) ? '0 : len;
    b_dots = (in_base || fresh) ? 1'b1 : dots;
    fin_none = (b_len == '0) || (b_dots && (b_len == LEN_W'(1)));
    fin_up = b_dots && (b_len == LEN_W'(2));
    comp_end = SUM_W'(mark) + SUM_W'(1) + SUM_W'(b_len);
    byte_pos = SUM_W'(mark) + SUM_W'(1) + SUM_W'(len);
    len_inc = len + LEN_W'(1);
    grown_end = SUM_W'(mark) + SUM_W'(1) + SUM_W'(len_inc);
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    used_next = used;
    mark_next = mark;
    len_next = len;
    dots_next = dots;
    ovf_next = ovf;
    trim_next = trim;
    scan_next = scan;
    cur_byte_next = cur_byte;
    cur_end_next = cur_end;
    rd_ok_next = rd_ok;
    rsp_valid_next = rsp_valid && rsp_stall;
    rsp_next = rsp;
    q_pop = 1'b0;
    ram_we = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re = 1'b0;
    ram_raddr = '0;

    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (fresh) begin
            mark_next = '0;
          end
          case (q_item.kind)
            REQ_READ: begin
              ram_re = 1'b1;
              ram_raddr = q_item.index;
              rd_ok_next = q_item.rd_ok;
              state_next = ST_RDWAIT;
            end
            REQ_BASE: begin
              phase_next = in_base ? PH_BASE : phase;
              used_next = e_used;
              ovf_next = e_ovf;
              trim_next = e_trim;
              len_next = b_len;
              dots_next = b_dots;
              if (in_base && !e_ovf) begin
                if (SUM_W'(e_used) + SUM_W'(1) >= PATH_LIMIT) begin
                  ovf_next = 1'b1;
                end else begin
                  ram_we = 1'b1;
                  ram_waddr = e_used;
                  ram_wdata = q_item.path_byte;
                  used_next = e_used + PTR_W'(1);
                  if (!q_item.is_slash) begin
                    trim_next = e_used + PTR_W'(1);
                  end
                end
              end
            end
            default: begin
              // Relative byte or end of request.
              phase_next = PH_REL;
              trim_next = e_trim;
              used_next = b_used;
              ovf_next = b_ovf;
              len_next = b_len;
              dots_next = b_dots;
              cur_byte_next = q_item.path_byte;
              cur_end_next = (q_item.kind == REQ_END);
              if (q_item.kind == REQ_END) begin
                state_next = ST_FINAL;
              end
              if (!b_ovf) begin
                if ((q_item.kind == REQ_REL) && !q_item.is_slash) begin
                  if (b_len == '0) begin
                    // First byte of a component: its leading slash goes in first.
                    ram_we = 1'b1;
                    ram_waddr = b_used;
                    ram_wdata = SLASH;
                    mark_next = b_used;
                    dots_next = 1'b1;
                  end
                  state_next = ST_BYTE;
                end else begin
                  len_next = '0;
                  dots_next = 1'b1;
                  if (fin_none) begin
                    used_next = b_used;
                  end else if (fin_up) begin
                    if (mark == '0) begin
                      used_next = '0;
                    end else begin
                      scan_next = mark;
                      ram_re = 1'b1;
                      ram_raddr = mark - PTR_W'(1);
                      state_next = ST_SCAN;
                    end
                  end else if (comp_end >= PATH_LIMIT) begin
                    ovf_next = 1'b1;
                  end else begin
                    used_next = PTR_W'(comp_end);
                  end
                end
              end
            end
          endcase
        end
      end
      ST_BYTE: begin
        if (byte_pos < PATH_LIMIT) begin
          ram_we = 1'b1;
          ram_waddr = PTR_W'(byte_pos);
          ram_wdata = cur_byte;
        end
        if ((len_inc >= LEN_W'(3)) && (grown_end >= PATH_LIMIT)) begin
          ovf_next = 1'b1;
          len_next = '0;
          dots_next = 1'b1;
        end else begin
          len_next = len_inc;
          dots_next = dots && (cur_byte == DOT);
        end
        state_next = ST_IDLE;
      end
      ST_SCAN: begin
        // The read data is the byte just below the scan pointer.
        if (ram_rdata == SLASH) begin
          used_next = scan - PTR_W'(1);
          state_next = cur_end ? ST_FINAL : ST_IDLE;
        end else if (scan == PTR_W'(1)) begin
          used_next = '0;
          state_next = cur_end ? ST_FINAL : ST_IDLE;
        end else begin
          scan_next = scan - PTR_W'(1);
          ram_re = 1'b1;
          ram_raddr = scan - PTR_W'(2);
        end
      end
      ST_FINAL: begin
        if (out_free) begin
          rsp_valid_next = 1'b1;
          rsp_next.result_kind = RES_SUMMARY;
          rsp_next.data_byte = '0;
          rsp_next.too_long = ovf;
          if (ovf) begin
            rsp_next.path_length = '0;
          end else if (used == '0) begin
            // An empty result is the root.
            ram_we = 1'b1;
            ram_waddr = '0;
            ram_wdata = SLASH;
            used_next = PTR_W'(1);
            rsp_next.path_length = 8'd1;
          end else begin
            rsp_next.path_length = 8'(used);
          end
          phase_next = PH_DONE;
          state_next = ST_IDLE;
        end
      end
      ST_RDWAIT: begin
        if (out_free) begin
          rsp_valid_next = 1'b1;
          rsp_next.result_kind = RES_READ;
          rsp_next.data_byte = rd_ok ? ram_rdata : 8'd0;
          rsp_next.path_length = '0;
          rsp_next.too_long = 1'b0;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= PH_BASE;
      used <= '0;
      mark <= '0;
      len <= '0;
      dots <= 1'b1;
      ovf <= 1'b0;
      trim <= '0;
      cur_end <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      used <= used_next;
      mark <= mark_next;
      len <= len_next;
      dots <= dots_next;
      ovf <= ovf_next;
      trim <= trim_next;
      cur_end <= cur_end_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    scan <= scan_next;
    cur_byte <= cur_byte_next;
    rd_ok <= rd_ok_next;
    rsp <= rsp_next;
  end

endmodule

>>> design/path_normalizer.sv
// Top level of the path normalizer: front end, item queue and back end.
// The block joins a relative path onto a normalized base path held in a
// 256-byte buffer and resolves "." and ".." on the fly. The front end takes
// one item per cycle into a four-entry queue, so the request side stalls only
// when the back end falls behind. In the back end a base byte or a slash is
// handled in the idle state, any other relative byte also in the byte state
// (the buffer's single write port stores a component's leading slash and its
// first byte in turn), a read also in the read-wait state, and an end item
// also in the final state. A ".." walks back through the buffer one byte per
// cycle over its read port, one read for every byte it scans. A finished
// result waits in an output register while the next items are being worked
// on. Bytes of the buffer that were never written read back as unknown.
module path_normalizer
  import pn_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  logic    q_valid;
  q_item_t q_item;
  logic    q_pop;

  pn_front u_front (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  pn_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

endmodule

>>> design/pn_checker.sv
// Port-level checks of the path normalizer and their binding to the top level.
module pn_checker
  import pn_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  // A stalled result transfer keeps its payload.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  a_read_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.result_kind == RES_READ) |->
      (rsp.path_length == 8'd0) && !rsp.too_long)
    else $error("read result carries summary fields");

  a_summary_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.result_kind == RES_SUMMARY) |->
      (rsp.data_byte == 8'd0) && (!rsp.too_long || (rsp.path_length == 8'd0)))
    else $error("summary carries stray data");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result presented right after reset");

endmodule

bind path_normalizer pn_checker u_pn_checker (.*);
